// ----- design/bbal_pkg.sv -----
// shared types and constants for the buddy block allocator
package bbal_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 16;
  localparam int TAG_W  = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              status;
  } out_t;

  // smallest order whose block holds size+1 bytes: the bit length of size
  function automatic logic [TAG_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [TAG_W-1:0] ord;
    ord = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) ord = TAG_W'(i + 1);
    end
    return ord;
  endfunction

endpackage

// ----- design/bbal_ram.sv -----
// generic single-write, single-read ram with registered read data
module bbal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/buddy_block_allocator.sv -----
// buddy block allocator top level: command fsm over link and order-tag memories
//
// usage: drive item and raise start while busy is low; the command transfers
// at that clock edge. operation allocate returns the byte offset of a block of
// at least request_size+1 bytes (status 0) or status 1 when no block fits;
// operation free returns address 0, status 0.
// every command yields exactly one result, shown on result for one cycle with
// result_valid high. the receiver cannot stall, so the result must be taken
// in that cycle. busy stays high from the transfer until the result cycle,
// and a new command may transfer in the result cycle.
// allocate: searches the free lists upward from the requested order, pops a
// block and splits off one buddy per order down to the requested order; out
// of memory answers once the top list is found empty, and a request that is
// too large answers straight from idle without raising busy.
// free: reads the order tag, then per merge walks the free list of that order
// over the link memory for the buddy and unlinks it, then pushes the block.
// the link memory has one read and one write port, one access per state.
// reset: all free lists empty except the top order, which holds the whole
// pool at offset zero; no clearing pass is needed.
module buddy_block_allocator #(
  parameter int POOL_ORDER     = 16,
  parameter int SMALLEST_ORDER = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bbal_pkg::in_t item,
  output logic          result_valid,
  output bbal_pkg::out_t result
);

  localparam int UB     = POOL_ORDER - SMALLEST_ORDER;
  localparam int UNITS  = 1 << UB;
  localparam int LEVELS = UB + 1;
  localparam int LV_W   = $clog2(LEVELS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_POP    = 4'd2;
  localparam logic [3:0] S_SPLIT  = 4'd3;
  localparam logic [3:0] S_FTAG   = 4'd4;
  localparam logic [3:0] S_MSTART = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_UNLINK = 4'd8;
  localparam logic [3:0] S_PUSH   = 4'd9;

  logic [3:0]                   state;
  logic [UB:0]                  heads [LEVELS];
  logic [LV_W-1:0]              lv;
  logic [LV_W-1:0]              target;
  logic [UB-1:0]                blk;
  logic [UB-1:0]                prev;
  logic                         have_prev;
  logic [UB:0]                  cur;
  logic [UB:0]                  steps;
  logic [bbal_pkg::TAG_W-1:0]   ord;
  logic                         rz;
  logic                         link0_ok;

  logic                         link_we;
  logic [UB-1:0]                link_waddr;
  logic [UB:0]                  link_wdata;
  logic [UB-1:0]                link_raddr;
  logic [UB:0]                  link_rdata;
  logic [UB:0]                  lrd;
  logic                         tag_we;
  logic [UB-1:0]                tag_raddr;
  logic [bbal_pkg::TAG_W-1:0]   tag_rdata;

  logic [UB-1:0]                bud;
  logic [LV_W-1:0]              lv_dec;
  logic [UB-1:0]                bud_split;
  logic [UB-1:0]                free_blk;
  logic [UB+15:0]               free_wide;
  logic [POOL_ORDER+15:0]       addr_wide;
  logic [bbal_pkg::TAG_W-1:0]   ord_raw;
  logic [bbal_pkg::TAG_W-1:0]   ord_fl;
  logic                         too_big;
  logic [LV_W-1:0]              tag_lv;

  assign busy      = (state != S_IDLE);
  assign lv_dec    = lv - LV_W'(1);
  assign bud       = blk ^ (UB'(1) << lv);
  assign bud_split = blk ^ (UB'(1) << lv_dec);
  assign free_wide = (UB + 16)'(item.block_address >> SMALLEST_ORDER);
  assign free_blk  = free_wide[UB-1:0];
  assign addr_wide = (POOL_ORDER + 16)'(blk) << SMALLEST_ORDER;
  assign lrd       = rz ? '0 : link_rdata;

  always_comb begin
    ord_raw = bbal_pkg::size_order(item.request_size);
    ord_fl  = (int'(ord_raw) < SMALLEST_ORDER) ? bbal_pkg::TAG_W'(SMALLEST_ORDER) : ord_raw;
    too_big = int'(ord_fl) > POOL_ORDER;
    if (int'(tag_rdata) < SMALLEST_ORDER) begin
      tag_lv = '0;
    end else if (int'(tag_rdata) - SMALLEST_ORDER > UB) begin
      tag_lv = LV_W'(UB);
    end else begin
      tag_lv = LV_W'(int'(tag_rdata) - SMALLEST_ORDER);
    end
  end

  // memory port control, one access of each kind per state
  always_comb begin
    link_we    = 1'b0;
    link_waddr = blk;
    link_wdata = '0;
    link_raddr = cur[UB-1:0];
    tag_we     = 1'b0;
    tag_raddr  = free_blk;
    case (state)
      S_SEARCH: link_raddr = heads[lv][UB-1:0];
      S_SPLIT: begin
        if (lv != target) begin
          link_we    = 1'b1;
          link_waddr = bud_split;
        end else begin
          tag_we = 1'b1;
        end
      end
      S_WALK: link_raddr = (cur[UB-1:0] == bud) ? bud : cur[UB-1:0];
      S_UNLINK: begin
        if (have_prev) begin
          link_we    = 1'b1;
          link_waddr = prev;
          link_wdata = lrd;
        end
      end
      S_PUSH: begin
        link_we    = 1'b1;
        link_wdata = heads[lv];
      end
      default: ;
    endcase
  end

  bbal_ram #(.WIDTH(UB + 1), .DEPTH(UNITS)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  bbal_ram #(.WIDTH(bbal_pkg::TAG_W), .DEPTH(UNITS)) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (blk),
    .wdata (ord),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  always_ff @(posedge clk) begin
    // entry zero of the link memory reads empty until first written
    rz <= (link_raddr == '0) && !link0_ok;
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      link0_ok     <= 1'b0;
      for (int i = 0; i < LEVELS; i++) heads[i] <= (i == UB) ? {1'b1, UB'(0)} : '0;
    end else begin
      result_valid <= 1'b0;
      if (link_we && link_waddr == '0) link0_ok <= 1'b1;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (item.operation == bbal_pkg::OP_FREE) begin
              blk   <= free_blk;
              state <= S_FTAG;
            end else if (too_big) begin
              result       <= '{address: '0, status: bbal_pkg::ST_OOM};
              result_valid <= 1'b1;
            end else begin
              ord    <= ord_fl;
              lv     <= LV_W'(int'(ord_fl) - SMALLEST_ORDER);
              target <= LV_W'(int'(ord_fl) - SMALLEST_ORDER);
              state  <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (heads[lv][UB]) begin
            blk   <= heads[lv][UB-1:0];
            state <= S_POP;
          end else if (lv == LV_W'(UB)) begin
            result       <= '{address: '0, status: bbal_pkg::ST_OOM};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            lv <= lv + LV_W'(1);
          end
        end
        S_POP: begin
          heads[lv] <= lrd;
          state     <= S_SPLIT;
        end
        S_SPLIT: begin
          if (lv == target) begin
            result       <= '{address: addr_wide[15:0], status: bbal_pkg::ST_OK};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            lv            <= lv_dec;
            heads[lv_dec] <= {1'b1, bud_split};
          end
        end
        S_FTAG: begin
          lv    <= tag_lv;
          state <= S_MSTART;
        end
        S_MSTART: begin
          if (lv == LV_W'(UB)) begin
            state <= S_PUSH;
          end else begin
            cur       <= heads[lv];
            have_prev <= 1'b0;
            steps     <= '0;
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          if (!cur[UB] || steps == (UB + 1)'(UNITS)) begin
            state <= S_PUSH;
          end else if (cur[UB-1:0] == bud) begin
            state <= S_UNLINK;
          end else begin
            prev      <= cur[UB-1:0];
            have_prev <= 1'b1;
            steps     <= steps + (UB + 1)'(1);
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          cur   <= lrd;
          state <= S_WALK;
        end
        S_UNLINK: begin
          if (!have_prev) heads[lv] <= lrd;
          if (bud < blk) blk <= bud;
          lv    <= lv + LV_W'(1);
          state <= S_MSTART;
        end
        S_PUSH: begin
          heads[lv]    <= {1'b1, blk};
          result       <= '{address: '0, status: bbal_pkg::ST_OK};
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
